FILE: rtl/srhm_pkg.sv
// Shared types and constants of the sparse row heap merge multiply block.
// Holds the request/response item structs, input kind codes and register indexes.
// No dependencies.
package srhm_pkg;

   localparam int B_ENTRIES_DEF       = 4096;
   localparam int B_ROWS_DEF          = 4096;
   localparam int MAX_ROW_ENTRIES_DEF = 64;
   localparam int WINDOW_DEF          = 64;

   localparam int KEY_W = 17;
   localparam logic [KEY_W-1:0] KEY_DONE = 17'h10000;

   localparam logic [1:0] KIND_B_ENTRY = 2'd0;
   localparam logic [1:0] KIND_B_ROW   = 2'd1;
   localparam logic [1:0] KIND_A_ENTRY = 2'd2;
   localparam logic [1:0] KIND_UNUSED  = 2'd3;

   localparam logic CSR_WINDOW_LOW  = 1'b0;
   localparam logic CSR_WINDOW_HIGH = 1'b1;

   localparam logic [15:0] WINDOW_LOW_RESET  = 16'd0;
   localparam logic [16:0] WINDOW_HIGH_RESET = 17'd64;

   typedef struct packed {
      logic [1:0]         kind;
      logic [11:0]        position;
      logic [15:0]        column;
      logic [12:0]        row_begin;
      logic [12:0]        row_end;
      logic signed [31:0] value;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [15:0]        out_column;
      logic signed [63:0] sum;
      logic               end_of_row;
   } rsp_type;

endpackage

FILE: rtl/srhm_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// Used for the B column, B value, B row bound and heap stores. No dependencies.
module srhm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/sparse_row_heap_merge_multiply.sv
// A load item is stored without leaving idle. An A entry runs two binary searches
// over its B row; the final A entry also builds the heap and merges the products
// through it (one heap RAM read port). One item at a time; busy is high while an
// item is at work. Results come as one-cycle strobes on rsp_valid; the receiver
// cannot stall. Synchronous reset returns control to idle, sets the window registers
// to their reset values and clears the heap count; B and heap stores keep data.
module sparse_row_heap_merge_multiply
   import srhm_pkg::*;
#(
   parameter int B_ENTRIES       = B_ENTRIES_DEF,
   parameter int B_ROWS          = B_ROWS_DEF,
   parameter int MAX_ROW_ENTRIES = MAX_ROW_ENTRIES_DEF,
   parameter int WINDOW          = WINDOW_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [16:0] csr_wdata
);

   localparam int IW  = $clog2(B_ENTRIES);
   localparam int RW  = $clog2(B_ROWS);
   localparam int HW  = $clog2(MAX_ROW_ENTRIES);
   localparam int NW  = HW + 1;
   localparam int CW0 = $clog2(B_ENTRIES + 1);
   localparam int CW  = (CW0 > 13) ? CW0 : 13;
   localparam int EW  = 2 * CW + KEY_W + 32;

   typedef enum logic [4:0] {
      S_IDLE, S_BND_RD, S_BND, S_BS_STEP, S_BS_CMP, S_KEY, S_AC_DONE,
      S_HP_RD, S_HP_LOAD, S_HP_DEC, S_SF_START, S_SF_L, S_SF_R,
      S_MG_RD, S_MG_FIRST, S_MG_TOP, S_MG_MUL, S_MG_ADD, S_MG_CHECK, S_FINISH
   } state_type;

   state_type          state_ff;
   logic [15:0]        window_low_ff;
   logic [16:0]        window_high_ff;
   logic [RW-1:0]      pos_ff;
   logic [31:0]        mult_ff;
   logic               last_ff;
   logic [NW-1:0]      count_ff;
   logic [CW-1:0]      bs_first_ff, bs_stop_ff, row_stop_ff, start_ff, mid_ff;
   logic               phase_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [EW-1:0]      ent_ff, child_l_ff;
   logic [HW-1:0]      idx_ff, hp_i_ff;
   logic               ret_heap_ff, first_ff;
   logic signed [63:0] acc_ff, prod_ff;
   logic [KEY_W-1:0]   curcol_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   // window bounds
   logic [16:0] win_lo, win_hi, win_cap;
   always_comb begin
      win_lo  = {1'b0, window_low_ff};
      win_cap = win_lo + 17'(WINDOW);
      win_hi  = (window_high_ff > win_cap) ? win_cap : window_high_ff;
   end

   // memories
   logic          bent_we, bnd_we, heap_we;
   logic [IW-1:0] bcol_rd_addr, bval_rd_addr;
   logic [15:0]   bcol_rd;
   logic [31:0]   bval_rd;
   logic [RW-1:0] bnd_rd_addr;
   logic [25:0]   bnd_rd;
   logic [HW-1:0] heap_wr_addr, heap_rd_addr;
   logic [EW-1:0] heap_wr_data, heap_rd;

   srhm_ram #(.WIDTH(16), .DEPTH(B_ENTRIES)) u_bcol (
      .clock(clock), .wr_en(bent_we), .wr_addr(IW'(req_data.position)),
      .wr_data(req_data.column), .rd_addr(bcol_rd_addr), .rd_data(bcol_rd));

   srhm_ram #(.WIDTH(32), .DEPTH(B_ENTRIES)) u_bval (
      .clock(clock), .wr_en(bent_we), .wr_addr(IW'(req_data.position)),
      .wr_data(req_data.value), .rd_addr(bval_rd_addr), .rd_data(bval_rd));

   srhm_ram #(.WIDTH(26), .DEPTH(B_ROWS)) u_bnd (
      .clock(clock), .wr_en(bnd_we), .wr_addr(RW'(req_data.position)),
      .wr_data({req_data.row_begin, req_data.row_end}), .rd_addr(bnd_rd_addr),
      .rd_data(bnd_rd));

   srhm_ram #(.WIDTH(EW), .DEPTH(MAX_ROW_ENTRIES)) u_heap (
      .clock(clock), .wr_en(heap_we), .wr_addr(heap_wr_addr),
      .wr_data(heap_wr_data), .rd_addr(heap_rd_addr), .rd_data(heap_rd));

   function automatic logic [CW-1:0] clamp_addr(input logic [12:0] v);
      logic [CW-1:0] r;
      r = (32'(v) > 32'(B_ENTRIES)) ? CW'(B_ENTRIES) : CW'(v);
      return r;
   endfunction

   // heap entry layout: {cursor, stop, key, multiplier}
   logic [CW-1:0]    ent_cursor, ent_stop;
   logic [KEY_W-1:0] ent_key, lk, rk, hk, mk;
   assign ent_cursor = ent_ff[KEY_W+32+CW +: CW];
   assign ent_stop   = ent_ff[KEY_W+32 +: CW];
   assign ent_key    = ent_ff[32 +: KEY_W];
   assign lk         = child_l_ff[32 +: KEY_W];
   assign rk         = heap_rd[32 +: KEY_W];
   assign hk         = heap_rd[32 +: KEY_W];
   assign mk         = (lk < rk) ? lk : rk;

   // sift child indexes
   logic [HW+1:0] l_idx, r_idx, l_next, cnt_ext;
   always_comb begin
      cnt_ext = (HW+2)'(count_ff);
      l_idx   = {1'b0, idx_ff, 1'b1};
      l_next  = l_idx + 1'b1;
      r_idx   = (l_next < cnt_ext) ? l_next : cnt_ext - 1'b1;
   end

   logic [CW-1:0] bs_mid, next_addr;
   logic          bs_open;
   assign bs_open   = bs_first_ff < bs_stop_ff;
   assign bs_mid    = bs_first_ff + ((bs_stop_ff - bs_first_ff) >> 1);
   assign next_addr = ent_cursor + 1'b1;

   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod_in;
   assign mul_a   = bval_rd;
   assign mul_b   = ent_ff[31:0];
   assign prod_in = mul_a * mul_b;

   logic signed [64:0] sum65;
   logic signed [63:0] acc_sat;
   always_comb begin
      sum65 = {acc_ff[63], acc_ff} + {prod_ff[63], prod_ff};
      if (sum65[64] != sum65[63]) begin
         acc_sat = sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         acc_sat = sum65[63:0];
      end
   end

   logic [KEY_W-1:0] next_key;
   always_comb begin
      if (next_addr >= ent_stop || 32'(next_addr) >= 32'(B_ENTRIES) ||
          {1'b0, bcol_rd} <= ent_key || {1'b0, bcol_rd} >= win_hi) begin
         next_key = KEY_DONE;
      end else begin
         next_key = {1'b0, bcol_rd};
      end
   end

   logic accept, key_in_window;
   assign accept        = start && (state_ff == S_IDLE);
   assign key_in_window = ({1'b0, bcol_rd} >= win_lo) && ({1'b0, bcol_rd} < win_hi);

   always_comb begin
      bent_we = accept && req_data.kind == KIND_B_ENTRY &&
                32'(req_data.position) < 32'(B_ENTRIES);
      bnd_we  = accept && req_data.kind == KIND_B_ROW &&
                32'(req_data.position) < 32'(B_ROWS);
      bnd_rd_addr  = pos_ff;
      bcol_rd_addr = IW'(next_addr);
      bval_rd_addr = IW'(ent_cursor);
      if (state_ff == S_BS_STEP) begin
         bcol_rd_addr = bs_open ? IW'(bs_mid) : IW'(start_ff);
      end
      heap_rd_addr = '0;
      heap_we      = 1'b0;
      heap_wr_addr = idx_ff;
      heap_wr_data = ent_ff;
      unique case (state_ff)
         S_HP_RD:  heap_rd_addr = hp_i_ff;
         S_SF_START: begin
            heap_rd_addr = HW'(l_idx);
            heap_we      = !(l_idx < cnt_ext);
         end
         S_SF_L:   heap_rd_addr = HW'(r_idx);
         S_SF_R: begin
            heap_we = 1'b1;
            if (mk < ent_key) begin
               heap_wr_data = (lk == mk) ? child_l_ff : heap_rd;
            end
         end
         S_KEY: begin
            heap_we      = key_in_window;
            heap_wr_addr = HW'(count_ff);
            heap_wr_data = {start_ff, bs_first_ff, 1'b0, bcol_rd, mult_ff};
         end
         default: heap_rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         window_low_ff  <= WINDOW_LOW_RESET;
         window_high_ff <= WINDOW_HIGH_RESET;
         count_ff       <= '0;
         acc_ff         <= '0;
         curcol_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
         first_ff       <= 1'b0;
         ret_heap_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               CSR_WINDOW_LOW:  window_low_ff  <= csr_wdata[15:0];
               CSR_WINDOW_HIGH: window_high_ff <= csr_wdata;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (start && req_data.kind == KIND_A_ENTRY) begin
                  pos_ff  <= RW'(req_data.position);
                  mult_ff <= req_data.value;
                  last_ff <= req_data.last;
                  if (32'(req_data.position) < 32'(B_ROWS) &&
                      32'(count_ff) < 32'(MAX_ROW_ENTRIES) && win_hi > win_lo) begin
                     state_ff <= S_BND_RD;
                  end else begin
                     state_ff <= S_AC_DONE;
                  end
               end
            end
            S_BND_RD: state_ff <= S_BND;
            S_BND: begin
               if (clamp_addr(bnd_rd[25:13]) > clamp_addr(bnd_rd[12:0])) begin
                  state_ff <= S_AC_DONE;
               end else begin
                  bs_first_ff <= clamp_addr(bnd_rd[25:13]);
                  bs_stop_ff  <= clamp_addr(bnd_rd[12:0]);
                  row_stop_ff <= clamp_addr(bnd_rd[12:0]);
                  key_ff      <= win_lo;
                  phase_ff    <= 1'b0;
                  state_ff    <= S_BS_STEP;
               end
            end
            S_BS_STEP: begin
               if (bs_open) begin
                  mid_ff   <= bs_mid;
                  state_ff <= S_BS_CMP;
               end else if (!phase_ff) begin
                  // window start found; search the window end from there
                  start_ff   <= bs_first_ff;
                  bs_stop_ff <= row_stop_ff;
                  key_ff     <= win_hi;
                  phase_ff   <= 1'b1;
               end else if (start_ff < bs_first_ff) begin
                  state_ff <= S_KEY;
               end else begin
                  state_ff <= S_AC_DONE;
               end
            end
            S_BS_CMP: begin
               if ({1'b0, bcol_rd} < key_ff) begin
                  bs_first_ff <= mid_ff + 1'b1;
               end else begin
                  bs_stop_ff <= mid_ff;
               end
               state_ff <= S_BS_STEP;
            end
            S_KEY: begin
               if (key_in_window) begin
                  count_ff <= count_ff + 1'b1;
               end
               state_ff <= S_AC_DONE;
            end
            S_AC_DONE: begin
               if (!last_ff) begin
                  state_ff <= S_IDLE;
               end else if (count_ff == '0) begin
                  state_ff <= S_FINISH;
               end else if (count_ff == NW'(1)) begin
                  first_ff <= 1'b1;
                  state_ff <= S_MG_RD;
               end else begin
                  hp_i_ff  <= HW'((count_ff - NW'(2)) >> 1);
                  state_ff <= S_HP_RD;
               end
            end
            S_HP_RD: state_ff <= S_HP_LOAD;
            S_HP_LOAD: begin
               ent_ff      <= heap_rd;
               idx_ff      <= hp_i_ff;
               ret_heap_ff <= 1'b1;
               state_ff    <= S_SF_START;
            end
            S_HP_DEC: begin
               if (hp_i_ff == '0) begin
                  first_ff <= 1'b1;
                  state_ff <= S_MG_RD;
               end else begin
                  hp_i_ff  <= hp_i_ff - 1'b1;
                  state_ff <= S_HP_RD;
               end
            end
            S_SF_START: begin
               if (l_idx < cnt_ext) begin
                  state_ff <= S_SF_L;
               end else begin
                  state_ff <= ret_heap_ff ? S_HP_DEC : S_MG_RD;
               end
            end
            S_SF_L: begin
               child_l_ff <= heap_rd;
               state_ff   <= S_SF_R;
            end
            S_SF_R: begin
               if (mk < ent_key) begin
                  // move the smaller child up, follow the element down
                  idx_ff   <= (lk == mk) ? HW'(l_idx) : HW'(r_idx);
                  state_ff <= S_SF_START;
               end else begin
                  state_ff <= ret_heap_ff ? S_HP_DEC : S_MG_RD;
               end
            end
            S_MG_RD: state_ff <= first_ff ? S_MG_FIRST : S_MG_CHECK;
            S_MG_FIRST: begin
               ent_ff    <= heap_rd;
               curcol_ff <= hk;
               first_ff  <= 1'b0;
               state_ff  <= S_MG_TOP;
            end
            S_MG_TOP: state_ff <= (ent_key == KEY_DONE) ? S_FINISH : S_MG_MUL;
            S_MG_MUL: begin
               prod_ff  <= prod_in;
               ent_ff   <= {next_addr, ent_stop, next_key, ent_ff[31:0]};
               state_ff <= S_MG_ADD;
            end
            S_MG_ADD: begin
               acc_ff      <= acc_sat;
               idx_ff      <= '0;
               ret_heap_ff <= 1'b0;
               state_ff    <= S_SF_START;
            end
            S_MG_CHECK: begin
               ent_ff <= heap_rd;
               if (hk != curcol_ff) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.out_column  <= curcol_ff[15:0];
                  rsp_ff.sum         <= acc_ff;
                  rsp_ff.end_of_row  <= (hk == KEY_DONE);
                  acc_ff             <= '0;
               end
               curcol_ff <= hk;
               state_ff  <= S_MG_TOP;
            end
            S_FINISH: begin
               count_ff  <= '0;
               acc_ff    <= '0;
               curcol_ff <= '0;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside of a merge");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(MAX_ROW_ENTRIES))
      else $error("heap count beyond capacity");

   a_a_entry_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.kind == KIND_A_ENTRY) |=> busy)
      else $error("A entry accepted without going busy");

   a_merge_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |=> (count_ff == '0 && acc_ff == '0))
      else $error("merge end left state behind");
`endif

endmodule
